// ===== rtl/core/bjq_pkg.sv =====
// Shared types and constants for the bounded job queue with deadlines.
// No dependencies; every other file of the block but bjq_if imports this package.
package bjq_pkg;

    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic REQ_ARRIVE  = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        OUT_DONE  = 2'd0,
        OUT_ABORT = 2'd1,
        OUT_DROP  = 2'd2
    } t_outcome;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [15:0] duration;
        logic [31:0] deadline;
        logic [31:0] start;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
        logic set_start;
    } t_store_ctl;

endpackage

// ===== rtl/core/bjq_if.sv =====
// Request and result channel interfaces for the job queue.
// Depends on nothing; payload widths follow the block's fields.
interface bjq_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] job_id;
    logic [15:0] duration;
    logic [31:0] deadline;

    modport source (output valid, req_type, job_id, duration, deadline, input ready);
    modport sink   (input valid, req_type, job_id, duration, deadline, output ready);
endinterface

interface bjq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [15:0] done_id;
    logic [31:0] event_time;
    logic [31:0] delay;
    logic        last;

    modport source (output valid, outcome, done_id, event_time, delay, last, input ready);
    modport sink   (input valid, outcome, done_id, event_time, delay, last, output ready);
endinterface

// ===== rtl/core/bounded_job_queue_with_timeouts_unit.sv =====
// Channel   Dir  Payload                                        Request taken when
// i_req     in   req_type, job_id, duration, deadline           valid & ready
// o_res     out  outcome, done_id, event_time, delay, last      valid & ready
//
// Arrival: queued from idle, or, on a full queue, dropped through the result register.
// Advance: time + 1, then idle again on an empty queue; else the head is checked for done,
// then for deadline abort, and each ended job gives a result, all on one shared add/sub unit.
// Reset (i_rst_n low, synchronous): time = 1, queue empty, no result pending.
// A stalled o_res holds the sequencer in its emit step; i_req stays not ready.
// Top level of the job queue; depends on bjq_pkg, bjq_if, bjq_alu,
// bjq_store and bjq_seq.
module bounded_job_queue_with_timeouts_unit
    import bjq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bjq_in_if.sink    i_req,
    bjq_out_if.source o_res
);

    t_store_ctl  ctl;
    t_entry      new_entry;
    t_entry      head;
    logic [31:0] start_val;
    logic        empty;
    logic        full;
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    t_alu_op     alu_op;
    logic [31:0] alu_y;
    logic        alu_ge;

    bjq_alu u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_op (alu_op),
        .o_y  (alu_y),
        .o_ge (alu_ge)
    );

    bjq_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_new   (new_entry),
        .i_start (start_val),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    bjq_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .o_in_ready   (i_req.ready),
        .i_req_type   (i_req.req_type),
        .i_job_id     (i_req.job_id),
        .i_duration   (i_req.duration),
        .i_deadline   (i_req.deadline),
        .o_res_valid  (o_res.valid),
        .i_res_ready  (o_res.ready),
        .o_outcome    (o_res.outcome),
        .o_done_id    (o_res.done_id),
        .o_event_time (o_res.event_time),
        .o_delay      (o_res.delay),
        .o_last       (o_res.last),
        .o_ctl        (ctl),
        .o_new        (new_entry),
        .o_start      (start_val),
        .i_head       (head),
        .i_empty      (empty),
        .i_full       (full),
        .o_alu_a      (alu_a),
        .o_alu_b      (alu_b),
        .o_alu_op     (alu_op),
        .i_alu_y      (alu_y),
        .i_alu_ge     (alu_ge)
    );

endmodule

// ===== rtl/core/bjq_alu.sv =====
// Shared 32-bit add/subtract unit with unsigned compare flag.
// Depends on bjq_pkg (t_alu_op).
module bjq_alu
    import bjq_pkg::*;
(
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  t_alu_op     i_op,
    output logic [31:0] o_y,
    output logic        o_ge
);

    logic [31:0] b_eff;
    logic [32:0] sum;

    assign b_eff = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign sum   = {1'b0, i_a} + {1'b0, b_eff} + {32'd0, (i_op == ALU_SUB)};
    assign o_y   = sum[31:0];
    // carry out of a - b means a >= b (unsigned)
    assign o_ge  = sum[32];

endmodule

// ===== rtl/core/bjq_store.sv =====
// Circular job store: entries, head pointer and fill count.
// Depends on bjq_pkg (t_entry, t_store_ctl, depth constants).
module bjq_store
    import bjq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_store_ctl  i_ctl,
    input  t_entry      i_new,
    input  logic [31:0] i_start,
    output t_entry      o_head,
    output logic        o_empty,
    output logic        o_full
);

    t_entry             r_q [Q_DEPTH];
    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W:0]     tail_sum;
    logic [PTR_W-1:0]   tail;
    logic [PTR_W-1:0]   head_inc;

    assign tail_sum = {{(CNT_W + 1 - PTR_W){1'b0}}, r_head} + {1'b0, r_count};
    always_comb begin
        if (tail_sum >= (CNT_W + 1)'(Q_DEPTH)) begin
            tail = PTR_W'(tail_sum - (CNT_W + 1)'(Q_DEPTH));
        end else begin
            tail = PTR_W'(tail_sum);
        end
    end

    assign head_inc = (r_head == PTR_W'(Q_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctl.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_ctl.pop) begin
            r_head  <= head_inc;
            r_count <= r_count - CNT_W'(1);
        end
    end

    // entry payload has no reset; only written slots are ever read
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_q[tail] <= i_new;
        end
        if (i_ctl.set_start) begin
            r_q[r_head].start <= i_start;
        end
    end

    assign o_head  = r_q[r_head];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));

endmodule

// ===== rtl/core/bjq_seq.sv =====
// Sequencer: walks each request through the shared ALU, drives the store
// and holds the result output register. Depends on bjq_pkg.
module bjq_seq
    import bjq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [15:0] i_job_id,
    input  logic [15:0] i_duration,
    input  logic [31:0] i_deadline,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_outcome,
    output logic [15:0] o_done_id,
    output logic [31:0] o_event_time,
    output logic [31:0] o_delay,
    output logic        o_last,
    output t_store_ctl  o_ctl,
    output t_entry      o_new,
    output logic [31:0] o_start,
    input  t_entry      i_head,
    input  logic        i_empty,
    input  logic        i_full,
    output logic [31:0] o_alu_a,
    output logic [31:0] o_alu_b,
    output t_alu_op     o_alu_op,
    input  logic [31:0] i_alu_y,
    input  logic        i_alu_ge
);

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_ELAP, S_DCMP, S_DL, S_RES, S_LOOP, S_EMIT
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_now, n_now;
    logic        r_busy, n_busy;
    logic [31:0] r_tmp, n_tmp;
    t_outcome    r_kind, n_kind;
    logic        r_more, n_more;
    logic        r_held, n_held;
    t_outcome    r_res_outcome, n_res_outcome;
    logic [15:0] r_res_id, n_res_id;
    logic [31:0] r_res_time, n_res_time;
    logic [31:0] r_res_delay, n_res_delay;
    logic        r_o_valid, n_o_valid;
    logic [1:0]  r_o_outcome, n_o_outcome;
    logic [15:0] r_o_id, n_o_id;
    logic [31:0] r_o_time, n_o_time;
    logic [31:0] r_o_delay, n_o_delay;
    logic        r_o_last, n_o_last;
    logic        out_free;
    logic        more;

    assign out_free   = !r_o_valid || i_res_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_start    = r_now;

    always_comb begin
        o_new.id       = i_job_id;
        o_new.arrival  = r_now;
        o_new.duration = i_duration;
        o_new.deadline = i_deadline;
        o_new.start    = '0;
    end

    // idle head at or past its deadline gets aborted
    assign more = !i_empty && !r_busy && i_alu_ge;

    always_comb begin
        n_state       = r_state;
        n_now         = r_now;
        n_busy        = r_busy;
        n_tmp         = r_tmp;
        n_kind        = r_kind;
        n_more        = r_more;
        n_held        = r_held;
        n_res_outcome = r_res_outcome;
        n_res_id      = r_res_id;
        n_res_time    = r_res_time;
        n_res_delay   = r_res_delay;
        n_o_valid     = r_o_valid;
        n_o_outcome   = r_o_outcome;
        n_o_id        = r_o_id;
        n_o_time      = r_o_time;
        n_o_delay     = r_o_delay;
        n_o_last      = r_o_last;
        o_ctl         = '0;
        o_alu_a       = r_now;
        o_alu_b       = 32'd1;
        o_alu_op      = ALU_ADD;

        if (r_o_valid && i_res_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_ADVANCE) begin
                        n_state = S_START;
                    end else if (i_full) begin
                        n_res_outcome = OUT_DROP;
                        n_res_id      = i_job_id;
                        n_res_time    = r_now;
                        n_res_delay   = '0;
                        n_more        = 1'b0;
                        n_state       = S_EMIT;
                    end else begin
                        o_ctl.push = 1'b1;
                    end
                end
            end
            S_START: begin
                // ALU: now + 1
                n_now = i_alu_y;
                if (!i_empty) begin
                    if (!r_busy) begin
                        o_ctl.set_start = 1'b1;
                        n_busy          = 1'b1;
                    end
                    n_state = S_ELAP;
                end else begin
                    n_held  = 1'b0;
                    n_state = S_LOOP;
                end
            end
            S_ELAP: begin
                o_alu_a  = r_now;
                o_alu_b  = i_head.start;
                o_alu_op = ALU_SUB;
                n_tmp    = i_alu_y;
                n_state  = S_DCMP;
            end
            S_DCMP: begin
                o_alu_a  = r_tmp;
                o_alu_b  = {16'd0, i_head.duration};
                o_alu_op = ALU_SUB;
                if (i_alu_ge) begin
                    n_kind  = OUT_DONE;
                    n_state = S_RES;
                end else begin
                    n_state = S_DL;
                end
            end
            S_DL: begin
                o_alu_a  = i_head.deadline;
                o_alu_b  = r_now;
                o_alu_op = ALU_SUB;
                if (i_alu_y == '0) begin
                    n_kind  = OUT_ABORT;
                    n_state = S_RES;
                end else begin
                    n_held  = 1'b0;
                    n_state = S_LOOP;
                end
            end
            S_RES: begin
                o_alu_a  = (r_kind == OUT_DONE) ? i_head.start : r_now;
                o_alu_b  = i_head.arrival;
                o_alu_op = ALU_SUB;
                n_res_outcome = r_kind;
                n_res_id      = i_head.id;
                n_res_time    = r_now;
                n_res_delay   = i_alu_y;
                o_ctl.pop     = 1'b1;
                n_busy        = 1'b0;
                n_held        = 1'b1;
                n_state       = S_LOOP;
            end
            S_LOOP: begin
                o_alu_a  = r_now;
                o_alu_b  = i_head.deadline;
                o_alu_op = ALU_SUB;
                if (r_held) begin
                    // next abort decides whether the held result is the last
                    n_more  = more;
                    n_state = S_EMIT;
                end else if (more) begin
                    n_kind  = OUT_ABORT;
                    n_state = S_RES;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_outcome = r_res_outcome;
                    n_o_id      = r_res_id;
                    n_o_time    = r_res_time;
                    n_o_delay   = r_res_delay;
                    n_o_last    = !r_more;
                    n_held      = 1'b0;
                    if (r_more) begin
                        n_kind  = OUT_ABORT;
                        n_state = S_RES;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= 32'd1;
            r_busy    <= 1'b0;
            r_held    <= 1'b0;
            r_more    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_busy    <= n_busy;
            r_held    <= n_held;
            r_more    <= n_more;
            r_o_valid <= n_o_valid;
        end
        r_tmp         <= n_tmp;
        r_kind        <= n_kind;
        r_res_outcome <= n_res_outcome;
        r_res_id      <= n_res_id;
        r_res_time    <= n_res_time;
        r_res_delay   <= n_res_delay;
        r_o_outcome   <= n_o_outcome;
        r_o_id        <= n_o_id;
        r_o_time      <= n_o_time;
        r_o_delay     <= n_o_delay;
        r_o_last      <= n_o_last;
    end

    assign o_res_valid  = r_o_valid;
    assign o_outcome    = r_o_outcome;
    assign o_done_id    = r_o_id;
    assign o_event_time = r_o_time;
    assign o_delay      = r_o_delay;
    assign o_last       = r_o_last;

endmodule
